### rtl/span_min_max_gap_tracker_defines.svh
// Assertion macros for the span tracker. Both assume i_clk and i_rst_n in scope.
`ifndef SPAN_MIN_MAX_GAP_TRACKER_DEFINES_SVH
`define SPAN_MIN_MAX_GAP_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

`define SMMG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smmg check failed");

`define SMMG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smmg check failed");

`else

`define SMMG_ASSERT_IMPL(lbl, ante, cons)
`define SMMG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/smmg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smmg_pkg;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [31:0] GAP_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FEW  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GAP_LO,
        S_GAP_HI,
        S_SPAN
    } t_state;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] longest_span;
        logic [31:0] shortest_span;
        logic [8:0]  stored_count;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/smmg_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module smmg_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/smmg_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared subtract and compare: difference of two biased values and a test
// against the current smallest gap.
module smmg_alu (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_lim,
    output logic      [31:0] o_diff,
    output logic             o_less
);

    assign o_diff = i_a - i_b;
    assign o_less = (o_diff < i_lim);

endmodule

`default_nettype wire

### rtl/span_min_max_gap_tracker.sv
// Add with values held: busy while S_SCAN reads the value memory through its
// registered read port, then in S_GAP_LO and S_GAP_HI for the gap updates; the strobe
// is registered from S_GAP_HI. Add into an empty set skips S_SCAN. A new item is taken
// only while idle. Refused add or short query: strobe in the cycle after accept, no busy
// time. Full query: busy in S_SPAN, strobe registered from it.
// Synchronous active-low reset clears count, min, max, capacity; gap to all ones.
`timescale 1ns / 1ps
`default_nettype none
`include "span_min_max_gap_tracker_defines.svh"

module span_min_max_gap_tracker #(
    parameter int DEPTH = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [8:0]          i_cfg_wdata,
    input  wire logic                start,
    output logic                     busy,
    input  wire smmg_pkg::t_in_item  i_in,
    output logic                     o_res_valid,
    output smmg_pkg::t_out_item      o_res
);

    import smmg_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    t_state       r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic         r_pend, n_pend;
    logic [31:0]  r_min, n_min;
    logic [31:0]  r_max, n_max;
    logic [31:0]  r_gap, n_gap;
    logic [31:0]  r_b, n_b;
    logic [31:0]  r_lo, n_lo;
    logic [31:0]  r_hi, n_hi;
    logic         r_have_lo, n_have_lo;
    logic         r_have_hi, n_have_hi;
    logic [8:0]   r_cap;
    t_out_item    r_res, n_res;
    logic         r_res_valid, n_res_valid;

    logic         accept;
    logic         full;
    logic         rd_en;
    logic         mem_we;
    logic [31:0]  mem_q;
    logic [31:0]  biased;
    logic [31:0]  alu_a, alu_b, alu_diff;
    logic         alu_less;

    assign accept = start && (r_state == S_IDLE);
    assign biased = i_in.value ^ SIGN_BIAS;
    assign full   = (CMPW'(r_count) >= CMPW'(r_cap)) || (r_count >= CW'(DEPTH));
    assign rd_en  = (r_state == S_SCAN) && (r_idx < r_count);
    assign mem_we = accept && (i_in.kind == KIND_ADD) && !full;

    smmg_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (biased),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_q)
    );

    always_comb begin
        unique case (r_state)
            S_GAP_LO: begin
                alu_a = r_b;
                alu_b = r_lo;
            end
            S_GAP_HI: begin
                alu_a = r_hi;
                alu_b = r_b;
            end
            S_SPAN: begin
                alu_a = r_max;
                alu_b = r_min;
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    smmg_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_lim  (r_gap),
        .o_diff (alu_diff),
        .o_less (alu_less)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_min       = r_min;
        n_max       = r_max;
        n_gap       = r_gap;
        n_b         = r_b;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_have_lo   = r_have_lo;
        n_have_hi   = r_have_hi;
        n_res       = r_res;
        n_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.kind == KIND_ADD) begin
                        if (full) begin
                            n_res       = '{ST_FULL, 32'd0, 32'd0, 9'(r_count)};
                            n_res_valid = 1'b1;
                        end else begin
                            n_b       = biased;
                            n_idx     = '0;
                            n_have_lo = 1'b0;
                            n_have_hi = 1'b0;
                            n_state   = (r_count == '0) ? S_GAP_LO : S_SCAN;
                        end
                    end else if (r_count < CW'(2)) begin
                        n_res       = '{ST_FEW, 32'd0, 32'd0, 9'(r_count)};
                        n_res_valid = 1'b1;
                    end else begin
                        n_state = S_SPAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
                // read data arrives in the cycle after its address
                if (r_pend) begin
                    if (mem_q <= r_b && (!r_have_lo || mem_q > r_lo)) begin
                        n_lo      = mem_q;
                        n_have_lo = 1'b1;
                    end
                    if (mem_q >= r_b && (!r_have_hi || mem_q < r_hi)) begin
                        n_hi      = mem_q;
                        n_have_hi = 1'b1;
                    end
                end
                if (!rd_en && !r_pend) begin
                    n_state = S_GAP_LO;
                end
            end
            S_GAP_LO: begin
                if (r_have_lo && alu_less) begin
                    n_gap = alu_diff;
                end
                n_state = S_GAP_HI;
            end
            S_GAP_HI: begin
                if (r_have_hi && alu_less) begin
                    n_gap = alu_diff;
                end
                if (r_count == '0) begin
                    n_min = r_b;
                    n_max = r_b;
                end else begin
                    if (r_b < r_min) n_min = r_b;
                    if (r_b > r_max) n_max = r_b;
                end
                n_count     = r_count + 1'b1;
                n_res       = '{ST_OK, 32'd0, 32'd0, 9'(r_count + 1'b1)};
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SPAN: begin
                n_res       = '{ST_OK, alu_diff, r_gap, 9'(r_count)};
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_min       <= '0;
            r_max       <= '0;
            r_gap       <= GAP_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_min       <= n_min;
            r_max       <= n_max;
            r_gap       <= n_gap;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_b       <= n_b;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_have_lo <= n_have_lo;
        r_have_hi <= n_have_hi;
        r_res     <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `SMMG_ASSERT_IMPL(a_idx_in_range, r_state == S_SCAN, r_idx <= r_count)
    `SMMG_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `SMMG_ASSERT_NEXT(a_gap_hi_ends, r_state == S_GAP_HI, o_res_valid && r_state == S_IDLE)
    `SMMG_ASSERT_IMPL(a_no_write_busy, mem_we, r_state == S_IDLE && !full)

endmodule

`default_nettype wire
